[src/fba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

   localparam int MAX_FRAMES_DEF = 4096;
   localparam int WORD_BITS_DEF  = 32;

   localparam int ACTION_W = 1;
   localparam int FRAME_W  = 12;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 13;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_ALLOCATED = 3'd0,
      STS_MAPPED    = 3'd1,
      STS_NO_FREE   = 3'd2,
      STS_FREED     = 3'd3,
      STS_IGNORED   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SEARCH,
      FSM_FREE_WR,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic                 valid;
      logic [FRAME_W-1:0]   frame;
      status_type           status;
   } result_type;

endpackage

`default_nettype wire

[src/fba_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module fba_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/fba_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fba_ctrl
   import fba_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_action,
   input  wire logic [FRAME_W-1:0] req_frame,
   output logic                    req_ready,
   input  wire logic [COUNT_W-1:0] frame_count,
   output result_type              res,
   input  wire logic               res_ready
);

   // WORD_BITS is a power of two
   localparam int WL        = $clog2(WORD_BITS);
   localparam int MAP_WORDS = MAX_FRAMES / WORD_BITS;
   localparam int DEPTH     = (MAP_WORDS > 1) ? MAP_WORDS : 1;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW        = $clog2(MAP_WORDS + 1) > 0 ? $clog2(MAP_WORDS + 1) : 1;
   localparam int MFW       = $clog2(MAX_FRAMES + 1);
   localparam int LW        = (MFW > COUNT_W) ? MFW : COUNT_W;
   localparam int FX_W      = (AW + WL > FRAME_W) ? AW + WL : FRAME_W;

   fsm_type state_ff, state_in;

   logic [AW-1:0]      clr_ff, clr_in;
   logic [IW-1:0]      issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      chk_ff, chk_in;
   logic [WL-1:0]      bit_ff, bit_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   status_type         status_ff, status_in;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_wa, ram_ra;
   logic [WORD_BITS-1:0] ram_wd, ram_rd;

   logic [LW-1:0]        cnt_ext, limit, nwords;
   logic                 more, found, full;
   logic [WL-1:0]        zidx;
   logic [FX_W-1:0]      fr_ext, w_full, found_ext;
   logic                 fits_map;
   logic [WORD_BITS-1:0] set_mask, clr_mask;

   fba_ram #(
      .WIDTH  (WORD_BITS),
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // only whole words below the clamped count are searched
   assign cnt_ext = LW'(frame_count);
   assign limit   = (cnt_ext > LW'(MAX_FRAMES)) ? LW'(MAX_FRAMES) : cnt_ext;
   assign nwords  = limit >> WL;
   assign more    = LW'(issue_ff) < nwords;

   always_comb begin
      zidx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!ram_rd[i]) begin
            zidx = WL'(i);
         end
      end
   end

   assign full      = &ram_rd;
   assign found     = pend_ff && !full;
   assign found_ext = FX_W'({chk_ff, zidx});
   assign set_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << zidx;
   assign clr_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_ff;

   assign fr_ext   = FX_W'(req_frame);
   assign w_full   = fr_ext >> WL;
   assign fits_map = w_full < FX_W'(MAP_WORDS);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_FREE) begin
                  if (req_frame != '0 && fits_map) begin
                     state_in = FSM_FREE_WR;
                  end else begin
                     state_in = FSM_DONE;
                  end
               end else if (req_frame == '0 && nwords != '0) begin
                  state_in = FSM_SEARCH;
               end else begin
                  state_in = FSM_DONE;
               end
            end
         end
         FSM_SEARCH: begin
            if (found || !more) begin
               state_in = FSM_DONE;
            end
         end
         FSM_FREE_WR: state_in = FSM_DONE;
         FSM_DONE: begin
            if (res_ready) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_CLEAR;
      endcase
   end

   always_comb begin
      clr_in    = clr_ff;
      issue_in  = issue_ff;
      pend_in   = pend_ff;
      chk_in    = chk_ff;
      bit_in    = bit_ff;
      frame_in  = frame_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_wa    = chk_ff;
      ram_wd    = '0;
      ram_re    = 1'b0;
      ram_ra    = issue_ff[AW-1:0];
      req_ready = 1'b0;
      res       = '{valid: 1'b0, frame: frame_ff, status: status_ff};
      unique case (state_ff)
         FSM_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         FSM_IDLE: begin
            req_ready = 1'b1;
            issue_in  = '0;
            pend_in   = 1'b0;
            if (req_valid) begin
               frame_in = '0;
               if (req_action == ACT_FREE) begin
                  if (req_frame == '0) begin
                     status_in = STS_IGNORED;
                  end else begin
                     status_in = STS_FREED;
                     if (fits_map) begin
                        ram_re = 1'b1;
                        ram_ra = w_full[AW-1:0];
                        chk_in = w_full[AW-1:0];
                        bit_in = fr_ext[WL-1:0];
                     end
                  end
               end else if (req_frame != '0) begin
                  frame_in  = req_frame;
                  status_in = STS_MAPPED;
               end else begin
                  status_in = STS_NO_FREE;
               end
            end
         end
         FSM_SEARCH: begin
            if (found) begin
               // set the bit in the word just read
               ram_we    = 1'b1;
               ram_wa    = chk_ff;
               ram_wd    = ram_rd | set_mask;
               frame_in  = found_ext[FRAME_W-1:0];
               status_in = STS_ALLOCATED;
            end else if (more) begin
               ram_re   = 1'b1;
               ram_ra   = issue_ff[AW-1:0];
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
               chk_in   = issue_ff[AW-1:0];
            end
         end
         FSM_FREE_WR: begin
            ram_we = 1'b1;
            ram_wa = chk_ff;
            ram_wd = ram_rd & ~clr_mask;
         end
         FSM_DONE: begin
            res.valid = 1'b1;
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
         issue_ff <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff    <= chk_in;
      bit_ff    <= bit_in;
      frame_ff  <= frame_in;
      status_ff <= status_in;
   end

endmodule

`default_nettype wire

[src/frame_bitmap_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word
// req_      in         tuser[0] action, tdata[11:0] page_frame
// rsp_      out        tuser[2:0] status, tdata[11:0] new_frame
// csr_      in         data[12:0] frame_count
//
// After reset the bitmap memory is swept to zero, one word a cycle, MAX_FRAMES/WORD_BITS
// words (128 by default); no request is taken meanwhile, csr writes are.
// An allocation with page_frame zero reads one word a cycle, in order, over the first
// W = min(frame_count, MAX_FRAMES)/WORD_BITS words; when W is 0 it reads none and reports no free.
// A free of a nonzero frame in the map: read, write back, result; other requests: result only.
// The result register lets the next request in while rsp_ is stalled.

module frame_bitmap_allocator
   import fba_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [15:0]        req_tdata,   // [11:0] page_frame
   input  wire logic [0:0]         req_tuser,   // [0] action
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic      [15:0]        rsp_tdata,   // [11:0] new_frame
   output logic      [2:0]         rsp_tuser,   // [2:0] status
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data     // [12:0] frame_count
);

   logic [COUNT_W-1:0] count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   status_type         rsp_status_ff, rsp_status_in;
   result_type         res;
   logic               res_ready;

   fba_ctrl #(
      .MAX_FRAMES (MAX_FRAMES),
      .WORD_BITS  (WORD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_action  (req_tuser[0]),
      .req_frame   (req_tdata[FRAME_W-1:0]),
      .req_ready   (req_tready),
      .frame_count (count_ff),
      .res         (res),
      .res_ready   (res_ready)
   );

   assign csr_ready = 1'b1;
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      if (res_ready) begin
         // load the next word, or drop the one just taken
         rsp_valid_in  = res.valid;
         rsp_frame_in  = res.frame;
         rsp_status_in = res.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            count_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_frame_ff);
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

[tb/fba_checker.sv]
`timescale 1ns / 1ps

module fba_checker
   import fba_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_tready,
   input  wire logic [15:0]        req_tdata,   // [11:0] page_frame
   input  wire logic [0:0]         req_tuser,   // [0] action
   input  wire logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire logic [15:0]        rsp_tdata,   // [11:0] new_frame
   input  wire logic [2:0]         rsp_tuser,   // [2:0] status
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data,    // [12:0] frame_count
   output int                      fail_count,
   output int                      pending_count,
   output int                      checked_count
);

   localparam int MAP_WORDS = MAX_FRAMES_DEF / WORD_BITS_DEF;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      status_type         status;
   } grant_type;

   logic [WORD_BITS_DEF-1:0] frame_map [MAP_WORDS];
   logic [COUNT_W-1:0]       frames_managed;
   grant_type                grant_q [$];

   task automatic report_mismatch(input string what);
      $display("fba_checker: %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // First fit over whole words below the managed count; updates the map.
   task automatic predict_grant(input action_type act, input logic [FRAME_W-1:0] pf,
                                output grant_type g);
      int  limit;
      bit  hit;
      if (act == ACT_ALLOC) begin
         if (pf != '0) begin
            g = '{frame: pf, status: STS_MAPPED};
         end else begin
            limit = (frames_managed > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(frames_managed);
            hit = 1'b0;
            g = '{frame: '0, status: STS_NO_FREE};
            for (int w = 0; w < limit / WORD_BITS_DEF && !hit; w++) begin
               for (int b = 0; b < WORD_BITS_DEF && !hit; b++) begin
                  if (!frame_map[w][b]) begin
                     hit = 1'b1;
                     frame_map[w][b] = 1'b1;
                     g = '{frame: FRAME_W'(w * WORD_BITS_DEF + b), status: STS_ALLOCATED};
                  end
               end
            end
         end
      end else if (pf == '0) begin
         g = '{frame: '0, status: STS_IGNORED};
      end else begin
         frame_map[pf / WORD_BITS_DEF][pf % WORD_BITS_DEF] = 1'b0;
         g = '{frame: '0, status: STS_FREED};
      end
   endtask

   always @(posedge clock) begin : watch
      grant_type want;
      grant_type got;
      if (reset) begin
         for (int i = 0; i < MAP_WORDS; i++)
            frame_map[i] = '0;
         frames_managed = COUNT_RESET;
         grant_q.delete();
      end else begin
         // check the outgoing word before queueing the incoming one
         if (rsp_tvalid && rsp_tready) begin
            got = '{frame: rsp_tdata[FRAME_W-1:0], status: status_type'(rsp_tuser)};
            if (grant_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result frame %0d status %0d",
                                         got.frame, got.status));
            end else begin
               want = grant_q.pop_front();
               checked_count++;
               if (got.frame !== want.frame)
                  report_mismatch($sformatf("new_frame %0d, want %0d",
                                            got.frame, want.frame));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            got.status, want.status));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_grant(action_type'(req_tuser[0]), req_tdata[FRAME_W-1:0], want);
            grant_q.push_back(want);
         end
         if (csr_valid && csr_ready)
            frames_managed = csr_data;
      end
      pending_count = grant_q.size();
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import fba_pkg::*;

   localparam int SETTLE_CYCLES = 140;
   localparam int PHASE_ITEMS   = 160;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic [15:0]        req_tdata  = '0;
   logic [0:0]         req_tuser  = '0;
   logic               rsp_tready = 1'b1;
   logic               csr_valid  = 1'b0;
   logic [COUNT_W-1:0] csr_data   = '0;
   wire                req_tready;
   wire                rsp_tvalid;
   wire  [15:0]        rsp_tdata;
   wire  [2:0]         rsp_tuser;
   wire                csr_ready;

   int fail_count;
   int pending_count;
   int checked_count;
   int sent_count;
   int setting_count;
   int stall_left;
   bit sender_idles;
   bit receiver_stalls;
   logic [COUNT_W-1:0] frames_set = COUNT_RESET;

   frame_bitmap_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   fba_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(15_000_000);
      $display("tb_top: done, errors");
      $finish;
   end

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Called at a falling edge; returns at a falling edge with tvalid still high.
   task automatic send_word(input action_type act, input logic [FRAME_W-1:0] pf);
      int gap;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(16 - FRAME_W){1'b0}}, pf};
      req_tuser  <= act;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // Hold the request side until every expected result is back, then let
   // any search in flight run out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_frame_count(input logic [COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid  <= 1'b0;
      frames_set = value;
      setting_count++;
   endtask

   task automatic send_random_word();
      int pick;
      int top_frame;
      pick = $urandom_range(0, 99);
      if (frames_set == 0)
         top_frame = 31;
      else if (frames_set > MAX_FRAMES_DEF)
         top_frame = MAX_FRAMES_DEF - 1;
      else
         top_frame = frames_set - 1;
      if (pick < 55)
         send_word(ACT_ALLOC, '0);
      else if (pick < 70)
         send_word(ACT_ALLOC, FRAME_W'($urandom_range(1, 4095)));
      else if (pick < 93)
         send_word(ACT_FREE, FRAME_W'($urandom_range(0, top_frame)));
      else
         send_word(ACT_FREE, FRAME_W'($urandom_range(0, 4095)));
   endtask

   initial begin : stimulus
      logic [COUNT_W-1:0] phase_counts [10];
      phase_counts = '{13'd64, 13'd256, 13'd4096, 13'd32, 13'd8191,
                       13'd96, 13'd0, 13'd4127, 13'd1000, 13'd0};
      phase_counts[9] = COUNT_W'($urandom_range(0, 8191));
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_frame_count(13'd4096);
      // frame zero is handed out first, then mapped pages, frees of
      // frame zero, of unused frames and of the top frame
      send_word(ACT_ALLOC, '0);
      send_word(ACT_ALLOC, '0);
      send_word(ACT_ALLOC, '0);
      send_word(ACT_ALLOC, 12'hFFF);
      send_word(ACT_ALLOC, 12'd1);
      send_word(ACT_ALLOC, 12'h555);
      send_word(ACT_FREE, '0);
      send_word(ACT_FREE, 12'd1);
      send_word(ACT_FREE, 12'd1);
      send_word(ACT_FREE, 12'hFFF);
      send_word(ACT_FREE, 12'hAAA);
      send_word(ACT_ALLOC, '0);
      drain_results();

      // nothing searchable
      write_frame_count(13'd0);
      send_word(ACT_ALLOC, '0);
      send_word(ACT_FREE, 12'd2);
      drain_results();

      // partial last word is never searched
      write_frame_count(13'd31);
      send_word(ACT_ALLOC, '0);
      drain_results();

      // count above capacity
      write_frame_count(13'h1FFF);
      send_word(ACT_ALLOC, '0);
      send_word(ACT_ALLOC, '0);
      send_word(ACT_FREE, 12'd3);
      drain_results();

      for (int p = 0; p < 10; p++) begin
         write_frame_count(phase_counts[p]);
         sender_idles    = (p < 9) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (p < 9) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == PHASE_ITEMS / 2) begin
               req_tvalid <= 1'b0;
               wait (pending_count == 0);
               @(negedge clock);
            end
            send_random_word();
         end
         drain_results();
      end

      $display("tb_top: %0d requests sent, %0d results checked, %0d frame_count settings",
               sent_count, checked_count, setting_count);
      $display("tb_top: first fit, exhaustion, frees and counts above capacity exercised");
      if (fail_count == 0 && pending_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

[frame_bitmap_allocator.f]
src/fba_pkg.sv
src/fba_ram.sv
src/fba_ctrl.sv
src/frame_bitmap_allocator.sv
tb/fba_checker.sv
tb/tb_top.sv
